// ===== rtl/scvd_pkg.sv =====
// ----------------------------------------------------------------------------
// scvd_pkg
// Shared widths, display window limits, register map and colour decode for
// the character-cell video decoder.
// ----------------------------------------------------------------------------
package scvd_pkg;

  // field widths
  localparam int LINE_W   = 8;
  localparam int COL_W    = 6;
  localparam int FRAME_W  = 8;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int SOFS_W   = 13;
  localparam int AOFS_W   = 10;
  localparam int COLOUR_W = 4;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_BORDER_COLOUR = 1'b0;

  // display window
  localparam logic [LINE_W-1:0] DISP_FIRST_LINE = 8'd24;
  localparam logic [LINE_W-1:0] DISP_END_LINE   = 8'd216;
  localparam logic [COL_W-1:0]  DISP_FIRST_COL  = 6'd4;
  localparam logic [COL_W-1:0]  DISP_END_COL    = 6'd36;

  typedef logic [COLOUR_W-1:0] colour_idx_t;
  typedef logic [BYTE_W-1:0]   pixel_t;

  // index is bright:green:red:blue, pixel is Y:R:G:B; bright black stays black
  function automatic pixel_t colour_byte(input colour_idx_t idx);
    logic y;
    y = idx[3] & (idx[2:0] != 3'd0);
    return {4'd0, y, idx[1], idx[2], idx[0]};
  endfunction

  // one source pixel shown twice
  function automatic logic [2*BYTE_W-1:0] colour_half(input colour_idx_t idx);
    pixel_t b;
    b = colour_byte(idx);
    return {b, b};
  endfunction

endpackage

// ===== rtl/scvd_stream_if.sv =====
// ----------------------------------------------------------------------------
// scvd stream interfaces
// Valid/ready channels for character cells in and decoded pixel words out.
// ----------------------------------------------------------------------------
interface scvd_cell_if
  import scvd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LINE_W-1:0]  line;
  logic [COL_W-1:0]   cell_column;
  logic [FRAME_W-1:0] frame_count;
  logic [BYTE_W-1:0]  pixel_byte;
  logic [BYTE_W-1:0]  attr_byte;

  modport source (output valid, line, cell_column, frame_count, pixel_byte, attr_byte,
                  input ready);
  modport sink (input valid, line, cell_column, frame_count, pixel_byte, attr_byte,
                output ready);
endinterface

interface scvd_pix_if
  import scvd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word_0;
  logic [WORD_W-1:0] word_1;
  logic [WORD_W-1:0] word_2;
  logic [WORD_W-1:0] word_3;
  logic              in_display;
  logic [SOFS_W-1:0] screen_offset;
  logic [AOFS_W-1:0] attr_offset;

  modport source (output valid, word_0, word_1, word_2, word_3, in_display,
                  screen_offset, attr_offset, input ready);
  modport sink (input valid, word_0, word_1, word_2, word_3, in_display,
                screen_offset, attr_offset, output ready);
endinterface

// ===== rtl/spectrum_cell_video_decode.sv =====
// ----------------------------------------------------------------------------
// spectrum_cell_video_decode
// Decodes one attribute-display character cell into four words of doubled
// RGBY pixels, plus the cell's bitmap and attribute offsets.
//
// One cell is taken every clock while in_ch.ready is high. An accepted cell
// waits in the input register. The decode logic then loads the result
// register, which offers the result on out_ch. Throughput is one cell per
// cycle as long as the result side takes a transfer each cycle. When the
// result side stalls, the input register still holds one more cell before
// in_ch.ready drops. border_colour sits at byte address 0 of the APB port
// and should only be written while no cells are in flight.
// ----------------------------------------------------------------------------
module spectrum_cell_video_decode
  import scvd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  scvd_cell_if.sink             in_ch,
  scvd_pix_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // config register
  colour_idx_t border_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      border_r <= '0;
    end else if (cfg_wr && (cfg_paddr[CFG_ADDR_W-1] == REG_BORDER_COLOUR)) begin
      border_r <= cfg_pwdata[COLOUR_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_W-1] == REG_BORDER_COLOUR) begin
      cfg_prdata = {{(CFG_DATA_W-COLOUR_W){1'b0}}, border_r};
    end
  end

  // pipeline control
  logic s1_valid_r;
  logic out_valid_r;
  logic s2_adv;
  logic in_xfer;

  assign s2_adv       = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready  = ~s1_valid_r | s2_adv;
  assign in_xfer      = in_ch.valid & in_ch.ready;
  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input register
  logic [LINE_W-1:0] line_r;
  logic [COL_W-1:0]  col_r;
  logic              flash_ph_r;
  logic [BYTE_W-1:0] pix_r;
  logic [BYTE_W-1:0] attr_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      line_r     <= in_ch.line;
      col_r      <= in_ch.cell_column;
      flash_ph_r <= in_ch.frame_count[5];
      pix_r      <= in_ch.pixel_byte;
      attr_r     <= in_ch.attr_byte;
    end
  end

  // display window and offsets
  logic              disp;
  logic [LINE_W-1:0] v;
  logic [COL_W-1:0]  x_full;
  logic [4:0]        x;
  logic [SOFS_W-1:0] sofs_nxt;
  logic [AOFS_W-1:0] aofs_nxt;

  assign disp = (line_r >= DISP_FIRST_LINE) && (line_r < DISP_END_LINE) &&
                (col_r >= DISP_FIRST_COL) && (col_r < DISP_END_COL);
  assign v        = line_r - DISP_FIRST_LINE;
  assign x_full   = col_r - DISP_FIRST_COL;
  assign x        = x_full[4:0];
  assign sofs_nxt = disp ? {v[7:6], v[2:0], v[5:3], x} : '0;
  assign aofs_nxt = disp ? {v[7:3], x} : '0;

  // attribute decode
  colour_idx_t          paper_idx;
  colour_idx_t          ink_idx;
  logic [2*BYTE_W-1:0]  paper_h;
  logic [2*BYTE_W-1:0]  ink_h;
  logic [2*BYTE_W-1:0]  border_h;
  logic [BYTE_W-1:0]    p;
  logic [WORD_W-1:0]    words_nxt [4];

  assign paper_idx = attr_r[6:3];
  assign ink_idx   = {attr_r[6], attr_r[2:0]};
  assign paper_h   = colour_half(paper_idx);
  assign ink_h     = colour_half(ink_idx);
  assign border_h  = colour_half(border_r);
  assign p         = (attr_r[7] & flash_ph_r) ? ~pix_r : pix_r;

  // earlier pixel in the low half of each word
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (disp) begin
        words_nxt[k] = {(p[6-2*k] ? ink_h : paper_h),
                        (p[7-2*k] ? ink_h : paper_h)};
      end else begin
        words_nxt[k] = {border_h, border_h};
      end
    end
  end

  // result register
  logic [WORD_W-1:0] word0_r, word1_r, word2_r, word3_r;
  logic              disp_r;
  logic [SOFS_W-1:0] sofs_r;
  logic [AOFS_W-1:0] aofs_r;

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      word0_r <= words_nxt[0];
      word1_r <= words_nxt[1];
      word2_r <= words_nxt[2];
      word3_r <= words_nxt[3];
      disp_r  <= disp;
      sofs_r  <= sofs_nxt;
      aofs_r  <= aofs_nxt;
    end
  end

  assign out_ch.word_0        = word0_r;
  assign out_ch.word_1        = word1_r;
  assign out_ch.word_2        = word2_r;
  assign out_ch.word_3        = word3_r;
  assign out_ch.in_display    = disp_r;
  assign out_ch.screen_offset = sofs_r;
  assign out_ch.attr_offset   = aofs_r;

`ifndef SYNTHESIS
  // border results carry no offsets
  a_border_zero_ofs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !disp_r) |-> (sofs_r == '0) && (aofs_r == '0))
    else $error("border result with nonzero offset");

  // border results are one uniform colour
  a_border_uniform: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !disp_r) |-> (word0_r == word3_r) && (word1_r == word2_r) &&
                                 (word0_r == word1_r))
    else $error("border result words differ");

  // display offsets stay inside the screen
  a_ofs_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && disp_r) |-> (sofs_r < 13'd6144) && (aofs_r < 10'd768))
    else $error("display offset out of range");

  // a stalled cell in the input register is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_adv) |=> s1_valid_r)
    else $error("input register lost a cell");

  // a transfer on the input always lands in the input register
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted cell not captured");
`endif

endmodule
